>>> sv/fcpe_pkg.sv
// Shared constants, types and arithmetic helpers for the Fourier curve point evaluator.
package fcpe_pkg;

    localparam int MAX_HARMONIC = 16;
    localparam int TABLE_DEPTH  = MAX_HARMONIC + 1;
    localparam int HARM_W       = $clog2(TABLE_DEPTH);
    localparam int PHASE_BITS   = 16;
    localparam int COEF_BITS    = 32;
    localparam int NUM_TABLES   = 4;
    localparam int TRIG_W       = 16;
    localparam int SB           = PHASE_BITS - 6;
    localparam int IDX_W        = PHASE_BITS - 2 - SB;
    localparam int QS_DEPTH     = 17;
    localparam int ACC_W        = 64;
    localparam int MUL_B_W      = 33;
    localparam int FP_W         = 7;
    localparam int HC_W         = 5;
    localparam int N_W          = FP_W + HC_W;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    typedef enum logic [1:0] {
        TBL_RAD_COS  = 2'd0,
        TBL_RAD_SIN  = 2'd1,
        TBL_VERT_COS = 2'd2,
        TBL_VERT_SIN = 2'd3
    } coeff_table_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HARMONIC_COUNT = 2'd0,
        CFG_FIELD_PERIODS  = 2'd1,
        CFG_SYMMETRIC_MODE = 2'd2
    } cfg_reg_t;

    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef coef_t [NUM_TABLES-1:0] coef_row_t;
    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        acc_t val;
        logic sat;
    } add_res_t;

    localparam logic [14:0] QUARTER_SINE [QS_DEPTH] = '{
        15'd0, 15'd3212, 15'd6393, 15'd9512, 15'd12540, 15'd15447, 15'd18205,
        15'd20788, 15'd23170, 15'd25330, 15'd27246, 15'd28899, 15'd30274,
        15'd31357, 15'd32138, 15'd32610, 15'd32767
    };

    localparam logic [14:0] Q15_ONE = 15'd32767;

    // u runs from zero up to and including a quarter turn
    function automatic logic [14:0] sine_quarter(input logic [PHASE_BITS-2:0] u);
        logic [IDX_W-1:0] idx;
        logic [SB-1:0]    frac;
        logic [14:0]      base;
        logic [14:0]      diff;
        logic [15+SB:0]   prod;
        idx  = u[PHASE_BITS-3:SB];
        frac = u[SB-1:0];
        base = QUARTER_SINE[idx];
        diff = QUARTER_SINE[{1'b0, idx} + 1'b1] - base;
        prod = (16'(diff) * (SB+1)'(frac)) + (16+SB)'(1 << (SB - 1));
        if (u[PHASE_BITS-2])
            return Q15_ONE;
        return base + 15'(prod >> SB);
    endfunction

    function automatic trig_t sine_turn(input logic [PHASE_BITS-1:0] a);
        logic [1:0]            q;
        logic [PHASE_BITS-2:0] r;
        logic [PHASE_BITS-2:0] rm;
        logic [14:0]           m;
        q  = a[PHASE_BITS-1:PHASE_BITS-2];
        r  = {1'b0, a[PHASE_BITS-3:0]};
        rm = {1'b1, {(PHASE_BITS-2){1'b0}}} - r;
        m  = q[0] ? sine_quarter(rm) : sine_quarter(r);
        return q[1] ? -trig_t'({1'b0, m}) : trig_t'({1'b0, m});
    endfunction

    function automatic trig_t cosine_turn(input logic [PHASE_BITS-1:0] a);
        return sine_turn(a + PHASE_BITS'(1 << (PHASE_BITS - 2)));
    endfunction

    // Derivative pattern: cosine kind C,-S,-C,S; sine kind S,C,-S,-C
    function automatic trig_t deriv_trig(input logic sine_kind, input logic [1:0] j,
                                         input trig_t c, input trig_t s);
        logic [1:0] jj;
        trig_t      r;
        jj = sine_kind ? j + 2'd3 : j;
        unique case (jj)
            2'd0: r = c;
            2'd1: r = -s;
            2'd2: r = -c;
            default: r = s;
        endcase
        return r;
    endfunction

    function automatic add_res_t sat_add(input acc_t a, input acc_t b);
        logic signed [ACC_W:0] sum;
        add_res_t r;
        sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        r.sat = sum[ACC_W] != sum[ACC_W-1];
        if (r.sat)
            r.val = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            r.val = sum[ACC_W-1:0];
        return r;
    endfunction

    // (2*pi)^d in Q16.16
    function automatic logic signed [MUL_B_W-1:0] turn_scale(input logic [1:0] d);
        logic signed [MUL_B_W-1:0] r;
        unique case (d)
            2'd0: r = MUL_B_W'(65536);
            2'd1: r = MUL_B_W'(411775);
            2'd2: r = MUL_B_W'(2587258);
            default: r = MUL_B_W'(16256219);
        endcase
        return r;
    endfunction

    function automatic logic signed [MUL_B_W-1:0] binom(input logic [1:0] d,
                                                        input logic [1:0] k);
        logic [1:0] r;
        r = 2'd1;
        if ((d == 2'd3) && ((k == 2'd1) || (k == 2'd2)))
            r = 2'd3;
        else if ((d == 2'd2) && (k == 2'd1))
            r = 2'd2;
        return MUL_B_W'(r);
    endfunction

endpackage

>>> sv/fcpe_if.sv
// Request channels of the Fourier curve point evaluator.
interface fcpe_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 mode;
    logic [1:0]                           deriv_order;
    logic [1:0]                           coeff_table;
    logic [4:0]                           harmonic;
    logic signed [31:0]                   coeff_value;
    logic [15:0]                          phase;
    logic                                 last_point;

    modport source (output valid, mode, deriv_order, coeff_table, harmonic,
                    coeff_value, phase, last_point, input ready);
    modport sink   (input valid, mode, deriv_order, coeff_table, harmonic,
                    coeff_value, phase, last_point, output ready);
endinterface

interface fcpe_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] pos_x;
    logic signed [63:0] pos_y;
    logic signed [63:0] pos_z;
    logic               saturated;
    logic               last;

    modport source (output valid, pos_x, pos_y, pos_z, saturated, last, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, saturated, last, output ready);
endinterface

interface fcpe_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] addr;
    logic [7:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

>>> sv/fourier_curve_point_eval.sv
// Top level: request sequencer around the coefficient memory and the shared multiplier.
//
//  channel   dir   handshake      payload
//  in_ch     in    valid/ready    mode, deriv_order, coeff_table, harmonic, coeff_value,
//                                 phase, last_point
//  out_ch    out   valid/ready    pos_x, pos_y, pos_z, saturated, last
//  cfg       in    valid/ready    addr (register index), data
//
// One request at a time. A coefficient write does a row read, a merge and a write back.
// In an evaluate every product goes through the one multiplier.
// Reset clears the tables (row valid bits), config to its defaults and all control.
// A finished result waits in the output register; the next request is taken meanwhile.
module fourier_curve_point_eval (
    input  logic        clk,
    input  logic        rst_n,
    fcpe_in_if.sink     in_ch,
    fcpe_out_if.source  out_ch,
    fcpe_cfg_if.sink    cfg
);
    import fcpe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_WRD, S_WWR, S_HREAD, S_HANGLE, S_HTRIG, S_TSTART, S_TWAIT,
        S_TADD, S_FSTART, S_FWAIT1, S_FWAIT2, S_FADD, S_SSTART, S_SWAIT, S_DONE
    } state_t;

    state_t                 state_reg;
    logic [HC_W-1:0]        hcount_reg;
    logic [FP_W-1:0]        fp_reg;
    logic                   sym_reg;

    logic [1:0]             wtable_reg;
    logic [4:0]             wharm_reg;
    coef_t                  wcoef_reg;

    logic [1:0]             d_reg;
    logic [PHASE_BITS-1:0]  ph_reg;
    logic                   last_reg;
    trig_t                  bc_reg;
    trig_t                  bs_reg;
    logic [HARM_W-1:0]      i_reg;
    logic [N_W-1:0]         n_reg;
    logic [PHASE_BITS-1:0]  a_reg;
    coef_row_t              row_reg;
    trig_t                  c_reg;
    trig_t                  s_reg;
    logic [1:0]             k_reg;
    logic [1:0]             src_reg;
    logic [1:0]             m_reg;
    logic                   sel_reg;
    logic [1:0]             t_reg;
    acc_t                   v_reg;
    acc_t                   rad_reg [4];
    acc_t                   x_reg;
    acc_t                   y_reg;
    acc_t                   z_reg;
    logic                   sat_reg;

    logic                   out_valid_reg;
    acc_t                   out_x_reg;
    acc_t                   out_y_reg;
    acc_t                   out_z_reg;
    logic                   out_sat_reg;
    logic                   out_last_reg;

    logic                   in_acc;
    logic                   cfg_acc;
    logic                   mem_rd_en;
    logic [HARM_W-1:0]      mem_rd_addr;
    coef_row_t              mem_rd_data;
    logic                   mem_wr_en;
    coef_row_t              mem_wr_data;

    logic                   mul_start;
    acc_t                   mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic [4:0]             mul_shift;
    logic                   mul_busy;
    logic                   mul_done;
    acc_t                   mul_res;
    logic                   mul_sat;

    logic [1:0]             lane;
    coef_t                  coef_sel;
    logic [1:0]             pow;
    logic                   tkind;
    trig_t                  ttrig;
    trig_t                  ftrig;
    acc_t                   add_a;
    add_res_t               add_r;
    logic [HARM_W-1:0]      hc;
    logic [N_W+PHASE_BITS-1:0] angle_prod;
    logic                   wr_skip;
    acc_t                   scale_in;

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign cfg_acc = cfg.valid && cfg.ready;
    assign in_ch.ready = state_reg == S_IDLE;
    assign cfg.ready   = 1'b1;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.pos_x     = out_x_reg;
    assign out_ch.pos_y     = out_y_reg;
    assign out_ch.pos_z     = out_z_reg;
    assign out_ch.saturated = out_sat_reg;
    assign out_ch.last      = out_last_reg;

    fcpe_coef_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (wharm_reg[HARM_W-1:0]),
        .wr_data (mem_wr_data)
    );

    fcpe_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .shift  (mul_shift),
        .busy   (mul_busy),
        .done   (mul_done),
        .result (mul_res),
        .sat    (mul_sat)
    );

    always_comb
    begin
        hc = (hcount_reg > HC_W'(MAX_HARMONIC)) ? HARM_W'(MAX_HARMONIC)
                                                : hcount_reg[HARM_W-1:0];
        angle_prod = n_reg * ph_reg;
        wr_skip = (wharm_reg > 5'(MAX_HARMONIC)) ||
                  (((wtable_reg == TBL_RAD_SIN) || (wtable_reg == TBL_VERT_SIN)) &&
                   (wharm_reg == 5'd0));

        // term order per harmonic: radial cos, radial sin, vertical sin, vertical cos
        unique case (src_reg)
            2'd0: lane = TBL_RAD_COS;
            2'd1: lane = TBL_RAD_SIN;
            2'd2: lane = TBL_VERT_SIN;
            default: lane = TBL_VERT_COS;
        endcase
        coef_sel = row_reg[lane];
        pow      = src_reg[1] ? d_reg : k_reg;
        tkind    = (src_reg == 2'd1) || (src_reg == 2'd2);
        ttrig    = deriv_trig(tkind, pow, c_reg, s_reg);
        ftrig    = deriv_trig(sel_reg, d_reg - k_reg, bc_reg, bs_reg);

        unique case (t_reg)
            2'd0: scale_in = x_reg;
            2'd1: scale_in = y_reg;
            default: scale_in = z_reg;
        endcase

        if (state_reg == S_FADD)
            add_a = sel_reg ? y_reg : x_reg;
        else
            add_a = src_reg[1] ? z_reg : rad_reg[k_reg];
        add_r = sat_add(add_a, v_reg);

        mem_rd_en   = 1'b0;
        mem_rd_addr = i_reg;
        mem_wr_en   = 1'b0;
        mem_wr_data = mem_rd_data;
        mem_wr_data[wtable_reg] = wcoef_reg;
        if (state_reg == S_WRD)
        begin
            mem_rd_en   = !wr_skip;
            mem_rd_addr = wharm_reg[HARM_W-1:0];
        end
        else if (state_reg == S_HREAD)
        begin
            mem_rd_en = 1'b1;
        end
        if (state_reg == S_WWR)
            mem_wr_en = 1'b1;

        mul_start = 1'b0;
        mul_a     = mul_res;
        mul_b     = MUL_B_W'(binom(d_reg, k_reg));
        mul_shift = 5'd0;
        unique case (state_reg)
            S_TSTART:
            begin
                mul_start = 1'b1;
                mul_a     = ACC_W'(coef_sel);
                mul_b     = MUL_B_W'(ttrig);
                mul_shift = 5'd15;
            end
            S_TWAIT:
            begin
                mul_start = mul_done && (m_reg < pow);
                mul_b     = $signed({{(MUL_B_W-N_W){1'b0}}, n_reg});
            end
            S_FSTART:
            begin
                mul_start = 1'b1;
                mul_a     = rad_reg[k_reg];
                mul_b     = MUL_B_W'(ftrig);
                mul_shift = 5'd15;
            end
            S_FWAIT1:
            begin
                mul_start = mul_done;
            end
            S_SSTART:
            begin
                mul_start = 1'b1;
                mul_a     = scale_in;
                mul_b     = turn_scale(d_reg);
                mul_shift = 5'd16;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hcount_reg    <= '0;
            fp_reg        <= FP_W'(1);
            sym_reg       <= 1'b1;
            wtable_reg    <= '0;
            wharm_reg     <= '0;
            wcoef_reg     <= '0;
            d_reg         <= '0;
            ph_reg        <= '0;
            last_reg      <= 1'b0;
            bc_reg        <= '0;
            bs_reg        <= '0;
            i_reg         <= '0;
            n_reg         <= '0;
            a_reg         <= '0;
            row_reg       <= '0;
            c_reg         <= '0;
            s_reg         <= '0;
            k_reg         <= '0;
            src_reg       <= '0;
            m_reg         <= '0;
            sel_reg       <= 1'b0;
            t_reg         <= '0;
            v_reg         <= '0;
            rad_reg       <= '{default: '0};
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_z_reg     <= '0;
            out_sat_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_acc)
            begin
                case (cfg.addr)
                    CFG_HARMONIC_COUNT: hcount_reg <= cfg.data[HC_W-1:0];
                    CFG_FIELD_PERIODS:  fp_reg     <= cfg.data[FP_W-1:0];
                    CFG_SYMMETRIC_MODE: sym_reg    <= cfg.data[0];
                    default:            ;
                endcase
            end

            // in S_DONE the output register is reloaded instead
            if (out_valid_reg && out_ch.ready && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        wtable_reg <= in_ch.coeff_table;
                        wharm_reg  <= in_ch.harmonic;
                        wcoef_reg  <= in_ch.coeff_value[COEF_BITS-1:0];
                        d_reg      <= in_ch.deriv_order;
                        ph_reg     <= in_ch.phase[PHASE_BITS-1:0];
                        last_reg   <= in_ch.last_point;
                        bc_reg     <= cosine_turn(in_ch.phase[PHASE_BITS-1:0]);
                        bs_reg     <= sine_turn(in_ch.phase[PHASE_BITS-1:0]);
                        i_reg      <= '0;
                        k_reg      <= '0;
                        src_reg    <= '0;
                        rad_reg    <= '{default: '0};
                        x_reg      <= '0;
                        y_reg      <= '0;
                        z_reg      <= '0;
                        sat_reg    <= 1'b0;
                        state_reg  <= (in_ch.mode == MODE_EVAL) ? S_HREAD : S_WRD;
                    end
                end
                S_WRD:
                begin
                    state_reg <= wr_skip ? S_IDLE : S_WWR;
                end
                S_WWR:
                begin
                    state_reg <= S_IDLE;
                end
                S_HREAD:
                begin
                    n_reg     <= fp_reg * i_reg;
                    state_reg <= S_HANGLE;
                end
                S_HANGLE:
                begin
                    a_reg     <= angle_prod[PHASE_BITS-1:0];
                    row_reg   <= mem_rd_data;
                    state_reg <= S_HTRIG;
                end
                S_HTRIG:
                begin
                    c_reg     <= cosine_turn(a_reg);
                    s_reg     <= sine_turn(a_reg);
                    state_reg <= S_TSTART;
                end
                S_TSTART:
                begin
                    m_reg     <= '0;
                    state_reg <= S_TWAIT;
                end
                S_TWAIT:
                begin
                    if (mul_done)
                    begin
                        v_reg   <= mul_res;
                        sat_reg <= sat_reg | mul_sat;
                        if (m_reg < pow)
                            m_reg <= m_reg + 2'd1;
                        else
                            state_reg <= S_TADD;
                    end
                end
                S_TADD:
                begin
                    sat_reg <= sat_reg | add_r.sat;
                    if (src_reg[1])
                        z_reg <= add_r.val;
                    else
                        rad_reg[k_reg] <= add_r.val;
                    priority if ((src_reg == 2'd0) && !sym_reg)
                    begin
                        src_reg   <= 2'd1;
                        state_reg <= S_TSTART;
                    end
                    else if (!src_reg[1] && (k_reg < d_reg))
                    begin
                        k_reg     <= k_reg + 2'd1;
                        src_reg   <= 2'd0;
                        state_reg <= S_TSTART;
                    end
                    else if (!src_reg[1])
                    begin
                        src_reg   <= 2'd2;
                        state_reg <= S_TSTART;
                    end
                    else if ((src_reg == 2'd2) && !sym_reg)
                    begin
                        src_reg   <= 2'd3;
                        state_reg <= S_TSTART;
                    end
                    else
                    begin
                        // harmonic finished
                        src_reg <= 2'd0;
                        k_reg   <= '0;
                        sel_reg <= 1'b0;
                        if (i_reg < hc)
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_HREAD;
                        end
                        else
                            state_reg <= S_FSTART;
                    end
                end
                S_FSTART:
                begin
                    state_reg <= S_FWAIT1;
                end
                S_FWAIT1:
                begin
                    if (mul_done)
                    begin
                        sat_reg   <= sat_reg | mul_sat;
                        state_reg <= S_FWAIT2;
                    end
                end
                S_FWAIT2:
                begin
                    if (mul_done)
                    begin
                        v_reg     <= mul_res;
                        sat_reg   <= sat_reg | mul_sat;
                        state_reg <= S_FADD;
                    end
                end
                S_FADD:
                begin
                    sat_reg <= sat_reg | add_r.sat;
                    if (sel_reg)
                        y_reg <= add_r.val;
                    else
                        x_reg <= add_r.val;
                    t_reg <= '0;
                    priority if (!sel_reg)
                    begin
                        sel_reg   <= 1'b1;
                        state_reg <= S_FSTART;
                    end
                    else if (k_reg < d_reg)
                    begin
                        sel_reg   <= 1'b0;
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= S_FSTART;
                    end
                    else
                        state_reg <= (d_reg != 2'd0) ? S_SSTART : S_DONE;
                end
                S_SSTART:
                begin
                    state_reg <= S_SWAIT;
                end
                S_SWAIT:
                begin
                    if (mul_done)
                    begin
                        sat_reg <= sat_reg | mul_sat;
                        unique case (t_reg)
                            2'd0: x_reg <= mul_res;
                            2'd1: y_reg <= mul_res;
                            default: z_reg <= mul_res;
                        endcase
                        if (t_reg < 2'd2)
                        begin
                            t_reg     <= t_reg + 2'd1;
                            state_reg <= S_SSTART;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= x_reg;
                        out_y_reg     <= y_reg;
                        out_z_reg     <= z_reg;
                        out_sat_reg   <= sat_reg;
                        out_last_reg  <= last_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // the multiplier takes one product at a time
    assert property (@(posedge clk) disable iff (!rst_n) mul_start |-> !mul_busy)
        else $error("multiplier started while busy");

    // every row write-back follows a read of the same row
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> ($past(mem_rd_en) && ($past(mem_rd_addr) == wharm_reg[HARM_W-1:0])))
        else $error("coefficient write without row read");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (!mul_busy && !mul_done))
        else $error("result ready with product in flight");

endmodule

>>> sv/fcpe_coef_mem.sv
// Coefficient memory: one row per harmonic holding all four table entries.
module fcpe_coef_mem (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [fcpe_pkg::HARM_W-1:0] rd_addr,
    output fcpe_pkg::coef_row_t       rd_data,
    input  logic                      wr_en,
    input  logic [fcpe_pkg::HARM_W-1:0] wr_addr,
    input  fcpe_pkg::coef_row_t       wr_data
);
    import fcpe_pkg::*;

    coef_row_t                  mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]     valid_reg;
    coef_row_t                  rd_data_reg;

    // rows never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/fcpe_mul.sv
// Shared rounding, saturating multiplier: round(a*b / 2^shift); it takes no new product while busy.
module fcpe_mul (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  fcpe_pkg::acc_t                     a,
    input  logic signed [fcpe_pkg::MUL_B_W-1:0] b,
    input  logic [4:0]                         shift,
    output logic                               busy,
    output logic                               done,
    output fcpe_pkg::acc_t                     result,
    output logic                               sat
);
    import fcpe_pkg::*;

    logic [1:0]  cnt_reg;
    logic [63:0] ma_reg;
    logic [31:0] mb_reg;
    logic        neg_reg;
    logic [4:0]  sh_reg;
    logic [63:0] pl_reg;
    logic [63:0] ph_reg;
    acc_t        res_reg;
    logic        sat_reg;
    logic        done_reg;

    logic [63:0] lim;
    logic [63:0] half;
    logic [63:0] low;
    logic [63:0] hp;
    logic [5:0]  up_sh;
    logic        sat_c;
    logic [63:0] mag;
    logic [63:0] abs_a;
    logic [MUL_B_W-1:0] abs_b;

    always_comb
    begin
        abs_a = a[ACC_W-1] ? 64'(-a) : 64'(a);
        abs_b = b[MUL_B_W-1] ? MUL_B_W'(-b) : MUL_B_W'(b);
        lim   = neg_reg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        half  = (sh_reg == 5'd0) ? 64'd0 : (64'd1 << (sh_reg - 5'd1));
        low   = (pl_reg + half) >> sh_reg;
        up_sh = 6'd32 - {1'b0, sh_reg};
        hp    = ph_reg << up_sh;
        sat_c = (ph_reg > (lim >> up_sh)) || (low > (lim - hp));
        mag   = sat_c ? lim : hp + low;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            done_reg <= 1'b0;
            ma_reg   <= '0;
            mb_reg   <= '0;
            neg_reg  <= 1'b0;
            sh_reg   <= '0;
            pl_reg   <= '0;
            ph_reg   <= '0;
            res_reg  <= '0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (cnt_reg)
                2'd0:
                begin
                    if (start)
                    begin
                        ma_reg  <= abs_a;
                        mb_reg  <= abs_b[31:0];
                        neg_reg <= a[ACC_W-1] != b[MUL_B_W-1];
                        sh_reg  <= shift;
                        cnt_reg <= 2'd1;
                    end
                end
                2'd1:
                begin
                    pl_reg  <= ma_reg[31:0] * mb_reg;
                    cnt_reg <= 2'd2;
                end
                2'd2:
                begin
                    ph_reg  <= ma_reg[63:32] * mb_reg;
                    cnt_reg <= 2'd3;
                end
                default:
                begin
                    res_reg  <= neg_reg ? acc_t'(-mag) : acc_t'(mag);
                    sat_reg  <= sat_c;
                    done_reg <= 1'b1;
                    cnt_reg  <= 2'd0;
                end
            endcase
        end
    end

    assign busy   = cnt_reg != 2'd0;
    assign done   = done_reg;
    assign result = res_reg;
    assign sat    = sat_reg;

endmodule

>>> tb/fourier_curve_point_eval_test.sv
// Self-checking testbench for the Fourier curve point evaluator: coefficient writes and point evaluations.
`timescale 1ns / 1ps

typedef struct {
    logic                     mode;
    logic [1:0]               deriv_order;
    fcpe_pkg::coeff_table_t   coeff_table;
    logic [4:0]               harmonic;
    logic signed [31:0]       coeff_value;
    logic [15:0]              phase;
    logic                     last_point;
} curve_req_t;

typedef struct {
    logic signed [63:0] pos_x;
    logic signed [63:0] pos_y;
    logic signed [63:0] pos_z;
    logic               saturated;
    logic               last;
} curve_point_t;

class curve_scoreboard;
    logic signed [63:0] coef_tab [4][17];
    int unsigned        harm_count;
    int unsigned        periods;
    bit                 symmetric;
    bit                 clamp_seen;
    curve_point_t       pending_points [$];
    int                 errors;
    int                 points_checked;
    int                 coef_writes;
    int                 sat_points;
    int                 sine_lut [17] = '{0, 3212, 6393, 9512, 12540, 15447, 18205, 20788,
                                          23170, 25330, 27246, 28899, 30274, 31357, 32138,
                                          32610, 32767};

    function new();
        foreach (coef_tab[t, h])
            coef_tab[t][h] = '0;
        harm_count = 0;
        periods = 1;
        symmetric = 1;
        errors = 0;
        points_checked = 0;
        coef_writes = 0;
        sat_points = 0;
    endfunction

    function void set_reg(fcpe_pkg::cfg_reg_t idx, logic [7:0] val);
        case (idx)
            fcpe_pkg::CFG_HARMONIC_COUNT: harm_count = val & 8'h1f;
            fcpe_pkg::CFG_FIELD_PERIODS:  periods = val & 8'h7f;
            fcpe_pkg::CFG_SYMMETRIC_MODE: symmetric = val[0];
            default: ;
        endcase
    endfunction

    function int sine_quarter(int u);
        int idx;
        int frac;
        if (u >= 16384)
            return 32767;
        idx = u >> 10;
        frac = u & 1023;
        return sine_lut[idx] + (((sine_lut[idx+1] - sine_lut[idx]) * frac + 512) >>> 10);
    endfunction

    function int sine_of(int a);
        int q;
        int r;
        q = (a >> 14) & 3;
        r = a & 16383;
        case (q)
            0: return sine_quarter(r);
            1: return sine_quarter(16384 - r);
            2: return -sine_quarter(r);
            default: return -sine_quarter(16384 - r);
        endcase
    endfunction

    function int cosine_of(int a);
        return sine_of((a + 16384) & 65535);
    endfunction

    // j-th derivative: cosine kind C,-S,-C,S; sine kind S,C,-S,-C
    function int trig_pattern(bit sine_kind, int j, int c, int s);
        int jj;
        jj = sine_kind ? (j + 3) & 3 : j & 3;
        case (jj)
            0: return c;
            1: return -s;
            2: return -c;
            default: return s;
        endcase
    endfunction

    // round(a*b / 2^sh), ties away from zero, clamped to 64 bits
    function logic signed [63:0] mul_round(logic signed [63:0] a, logic signed [63:0] b,
                                           int sh);
        logic signed [127:0] prod;
        logic [127:0]        mag;
        bit                  neg;
        prod = a;
        prod = prod * b;
        neg = prod < 0;
        mag = neg ? -prod : prod;
        if (sh > 0)
            mag = (mag + (128'd1 << (sh - 1))) >> sh;
        if (neg) begin
            if (mag > (128'd1 << 63)) begin
                clamp_seen = 1;
                return {1'b1, 63'd0};
            end
            return -$signed(mag[63:0]);
        end
        if (mag > ((128'd1 << 63) - 1)) begin
            clamp_seen = 1;
            return {1'b0, {63{1'b1}}};
        end
        return mag[63:0];
    endfunction

    function logic signed [63:0] add_clamp(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] sum;
        sum = {a[63], a} + {b[63], b};
        if (sum[64] != sum[63]) begin
            clamp_seen = 1;
            return sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return sum[63:0];
    endfunction

    function logic signed [63:0] harmonic_term(logic signed [63:0] coef, bit sine_kind, int k,
                                               int c, int s, int n);
        logic signed [63:0] v;
        v = mul_round(coef, trig_pattern(sine_kind, k, c, s), 15);
        repeat (k)
            v = mul_round(v, n, 0);
        return v;
    endfunction

    function curve_point_t eval_point(curve_req_t r);
        curve_point_t       pt;
        logic signed [63:0] rad [4];
        logic signed [63:0] xv;
        logic signed [63:0] yv;
        logic signed [63:0] zv;
        logic signed [63:0] tx;
        logic signed [63:0] ty;
        int                 d;
        int                 hc;
        int                 ph;
        int                 bc;
        int                 bs;
        int                 n;
        int                 c;
        int                 s;
        int                 binom_w;
        clamp_seen = 0;
        d = r.deriv_order;
        hc = harm_count > 16 ? 16 : harm_count;
        ph = r.phase;
        bc = cosine_of(ph);
        bs = sine_of(ph);
        foreach (rad[k])
            rad[k] = 0;
        xv = 0;
        yv = 0;
        zv = 0;
        for (int i = 0; i <= hc; i++) begin
            n = periods * i;
            c = cosine_of((n * ph) & 65535);
            s = sine_of((n * ph) & 65535);
            for (int k = 0; k <= d; k++) begin
                rad[k] = add_clamp(rad[k], harmonic_term(coef_tab[0][i], 0, k, c, s, n));
                if (!symmetric)
                    rad[k] = add_clamp(rad[k], harmonic_term(coef_tab[1][i], 1, k, c, s, n));
            end
            zv = add_clamp(zv, harmonic_term(coef_tab[3][i], 1, d, c, s, n));
            if (!symmetric)
                zv = add_clamp(zv, harmonic_term(coef_tab[2][i], 0, d, c, s, n));
        end
        for (int k = 0; k <= d; k++) begin
            binom_w = (d == 3 && (k == 1 || k == 2)) ? 3 : (d == 2 && k == 1) ? 2 : 1;
            tx = mul_round(rad[k], trig_pattern(0, d - k, bc, bs), 15);
            ty = mul_round(rad[k], trig_pattern(1, d - k, bc, bs), 15);
            xv = add_clamp(xv, mul_round(tx, binom_w, 0));
            yv = add_clamp(yv, mul_round(ty, binom_w, 0));
        end
        if (d > 0) begin
            // (2*pi)^d in Q16.16
            tx = d == 1 ? 64'sd411775 : d == 2 ? 64'sd2587258 : 64'sd16256219;
            xv = mul_round(xv, tx, 16);
            yv = mul_round(yv, tx, 16);
            zv = mul_round(zv, tx, 16);
        end
        pt.pos_x = xv;
        pt.pos_y = yv;
        pt.pos_z = zv;
        pt.saturated = clamp_seen;
        pt.last = r.last_point;
        return pt;
    endfunction

    function void note_request(curve_req_t r);
        if (r.mode == fcpe_pkg::MODE_WRITE) begin
            // sine tables have no harmonic zero entry; out-of-range harmonics are dropped
            if (r.harmonic > 16)
                return;
            if ((r.coeff_table == fcpe_pkg::TBL_RAD_SIN ||
                 r.coeff_table == fcpe_pkg::TBL_VERT_SIN) && r.harmonic == 0)
                return;
            coef_tab[r.coeff_table][r.harmonic] = r.coeff_value;
            coef_writes++;
        end else begin
            pending_points.push_back(eval_point(r));
        end
    endfunction

    function void check_result(curve_point_t got);
        curve_point_t want;
        if (pending_points.size() == 0) begin
            $error("result with no request outstanding");
            errors++;
            return;
        end
        want = pending_points.pop_front();
        points_checked++;
        if (want.saturated)
            sat_points++;
        if (got.pos_x !== want.pos_x) begin
            $error("pos_x expected %0d got %0d", want.pos_x, got.pos_x);
            errors++;
        end
        if (got.pos_y !== want.pos_y) begin
            $error("pos_y expected %0d got %0d", want.pos_y, got.pos_y);
            errors++;
        end
        if (got.pos_z !== want.pos_z) begin
            $error("pos_z expected %0d got %0d", want.pos_z, got.pos_z);
            errors++;
        end
        if (got.saturated !== want.saturated) begin
            $error("saturated expected %0d got %0d", want.saturated, got.saturated);
            errors++;
        end
        if (got.last !== want.last) begin
            $error("last expected %0d got %0d", want.last, got.last);
            errors++;
        end
    endfunction
endclass

module fourier_curve_point_eval_test;
    import fcpe_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;
    localparam int RANDOM_ITEMS = 550;

    logic clk;
    logic rst_n;
    int   cycles;
    bit   no_idle;

    fcpe_in_if  in_ch ();
    fcpe_out_if out_ch ();
    fcpe_cfg_if cfg_ch ();

    curve_scoreboard sb;

    fourier_curve_point_eval u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side: random back-pressure, checks every accepted result
    initial
    begin
        int stall;
        curve_point_t got;
        stall = 0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready) begin
                got.pos_x = out_ch.pos_x;
                got.pos_y = out_ch.pos_y;
                got.pos_z = out_ch.pos_z;
                got.saturated = out_ch.saturated;
                got.last = out_ch.last;
                sb.check_result(got);
            end
            if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                stall = gap_len();
            end
        end
    end

    task automatic send_request(curve_req_t r);
        in_ch.valid <= 1'b1;
        in_ch.mode <= r.mode;
        in_ch.deriv_order <= r.deriv_order;
        in_ch.coeff_table <= r.coeff_table;
        in_ch.harmonic <= r.harmonic;
        in_ch.coeff_value <= r.coeff_value;
        in_ch.phase <= r.phase;
        in_ch.last_point <= r.last_point;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_request(r);
    endtask

    task automatic idle_sender(int n);
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic write_coef(coeff_table_t t, logic [4:0] h, logic signed [31:0] v);
        curve_req_t r;
        r.mode = MODE_WRITE;
        r.deriv_order = 2'($urandom);
        r.coeff_table = t;
        r.harmonic = h;
        r.coeff_value = v;
        r.phase = 16'($urandom);
        r.last_point = 1'($urandom);
        send_request(r);
        idle_sender(gap_len());
    endtask

    task automatic eval_at(logic [1:0] d, logic [15:0] ph, logic lp);
        curve_req_t r;
        r.mode = MODE_EVAL;
        r.deriv_order = d;
        r.coeff_table = coeff_table_t'($urandom_range(0, 3));
        r.harmonic = 5'($urandom);
        r.coeff_value = $urandom;
        r.phase = ph;
        r.last_point = lp;
        send_request(r);
        idle_sender(gap_len());
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [7:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr <= idx;
        cfg_ch.data <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.set_reg(idx, val);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every outstanding point, then let a trailing write finish
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_points.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic configure(int hc, int fp, int sym);
        drain();
        write_reg(CFG_HARMONIC_COUNT, 8'(hc));
        write_reg(CFG_FIELD_PERIODS, 8'(fp));
        write_reg(CFG_SYMMETRIC_MODE, 8'(sym));
    endtask

    task automatic random_item(int hmax);
        int roll;
        logic signed [31:0] v;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            v = ($urandom_range(0, 3) == 0) ? $signed($urandom) :
                $signed(32'($urandom_range(0, 1 << 20)) - 32'(1 << 19));
            write_coef(coeff_table_t'($urandom_range(0, 3)),
                       ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, hmax)),
                       v);
        end else begin
            eval_at(2'($urandom), 16'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        int sent;
        int hc;
        sb = new();
        cycles = 0;
        no_idle = 0;
        rst_n = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.mode <= MODE_WRITE;
        in_ch.deriv_order <= '0;
        in_ch.coeff_table <= TBL_RAD_COS;
        in_ch.harmonic <= '0;
        in_ch.coeff_value <= '0;
        in_ch.phase <= '0;
        in_ch.last_point <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.addr <= CFG_HARMONIC_COUNT;
        cfg_ch.data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: cleared tables give zero
        eval_at(2'd0, 16'h0000, 1'b0);
        eval_at(2'd3, 16'hffff, 1'b1);

        configure(16, 1, 0);
        write_coef(TBL_RAD_COS, 5'd0, 32'sh0001_0000);
        write_coef(TBL_RAD_COS, 5'd16, 32'sh7fff_ffff);
        write_coef(TBL_RAD_SIN, 5'd16, 32'sh8000_0000);
        write_coef(TBL_VERT_COS, 5'd0, 32'sh0002_0000);
        write_coef(TBL_VERT_SIN, 5'd1, 32'shffff_0000);
        write_coef(TBL_RAD_SIN, 5'd0, 32'sh7fff_ffff);   // sine harmonic zero, dropped
        write_coef(TBL_VERT_SIN, 5'd0, 32'sh1234_5678);  // dropped
        write_coef(TBL_RAD_COS, 5'd17, 32'sh7fff_ffff);  // out of range, dropped
        write_coef(TBL_VERT_COS, 5'd31, 32'sh8000_0000); // dropped
        eval_at(2'd0, 16'h0000, 1'b0);
        eval_at(2'd1, 16'h4000, 1'b0);
        eval_at(2'd2, 16'h8000, 1'b0);
        eval_at(2'd3, 16'hffff, 1'b1);

        // harmonic count past the top, wide periods: saturation likely
        configure(31, 127, 0);
        eval_at(2'd3, 16'h1234, 1'b0);
        eval_at(2'd0, 16'hc000, 1'b1);

        // zero field periods, symmetric
        configure(3, 0, 1);
        eval_at(2'd1, 16'h5555, 1'b0);
        eval_at(2'd3, 16'haaaa, 1'b1);

        configure(16, 64, 1);
        eval_at(2'd2, 16'h0001, 1'b1);

        sent = 0;
        for (int p = 0; sent < RANDOM_ITEMS; p++) begin
            // most settings small so evaluations stay short
            if (p % 6 == 5)
                hc = ($urandom_range(0, 1) != 0) ? 16 : $urandom_range(17, 31);
            else
                hc = $urandom_range(0, 4);
            configure(hc, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 127),
                      $urandom_range(0, 1));
            no_idle = (p % 4 == 3);
            for (int j = 0; j < 40 && sent < RANDOM_ITEMS; j++) begin
                random_item(hc > 16 ? 16 : hc);
                sent++;
                if (j == 20 && p % 3 == 0)
                    drain();
            end
        end

        drain();
        repeat (100) @(posedge clk);
        $display("Covered %0d coefficient writes and %0d checked points (%0d saturated).",
                 sb.coef_writes, sb.points_checked, sb.sat_points);
        $display("Derivative orders 0..3, several register settings including the extremes.");
        if (sb.errors == 0 && sb.pending_points.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
